// File: sv/key_check_failure_throttle_unit_macros.svh
// Assertion macros shared by the throttle unit RTL.
`ifndef KEY_CHECK_FAILURE_THROTTLE_UNIT_MACROS_SVH
`define KEY_CHECK_FAILURE_THROTTLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define KCFT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kcft assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define KCFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kcft assertion failed");

`endif

// File: sv/kcft_pkg.sv
// Types and constants of the key check failure throttle unit.
package kcft_pkg;

	localparam int KEY_LEN_MAX = 31;
	localparam int KEY_WORDS = 4;
	localparam int WORD_W = 64;
	localparam int CFG_IDX_W = 4;
	localparam int TIME_W = 32;
	localparam int DUR_W = 31;

	typedef enum logic [1:0] {
		VERDICT_ALLOW = 2'd0,
		VERDICT_UNAUTH = 2'd1,
		VERDICT_THROTTLED = 2'd2
	} verdict_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SECRET_WORD0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECRET_WORD1 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECRET_WORD2 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SECRET_WORD3 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SECRET_LEN = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_LIMIT = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIKE_WINDOW = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT = 4'd7;

	localparam logic [7:0] STRIKE_LIMIT_RST = 8'd5;
	localparam logic [DUR_W-1:0] STRIKE_WINDOW_RST = 31'd60;
	localparam logic [DUR_W-1:0] LOCKOUT_RST = 31'd300;
	localparam logic [DUR_W-1:0] RETRY_MAX = '1;

	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_words_t;

	typedef struct packed {
		key_words_t secret;
		logic [4:0] secret_len;
		logic [7:0] strike_limit;
		logic [DUR_W-1:0] strike_window_s;
		logic [DUR_W-1:0] lockout_s;
	} cfg_t;

endpackage

// File: sv/kcft_ifs.sv
// Handshake channels of the throttle unit: attempts, results and register writes.
interface kcft_in_if import kcft_pkg::*; ();
	logic valid;
	logic ready;
	logic [WORD_W-1:0] try_word0;
	logic [WORD_W-1:0] try_word1;
	logic [WORD_W-1:0] try_word2;
	logic [WORD_W-1:0] try_word3;
	logic [5:0] try_len;
	logic [TIME_W-1:0] now_s;

	modport source (output valid, try_word0, try_word1, try_word2, try_word3, try_len,
		now_s, input ready);
	modport sink (input valid, try_word0, try_word1, try_word2, try_word3, try_len,
		now_s, output ready);
endinterface

interface kcft_out_if import kcft_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] verdict;
	logic locked_out;
	logic [DUR_W-1:0] retry_after_s;

	modport source (output valid, verdict, locked_out, retry_after_s, input ready);
	modport sink (input valid, verdict, locked_out, retry_after_s, output ready);
endinterface

interface kcft_cfg_if import kcft_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [WORD_W-1:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

// File: sv/key_check_failure_throttle_unit.sv
// Attempt throttle: accepts one key attempt per cycle while the result side does not stall;
// each attempt is taken into the input register and its result then into the result
// register, which holds while result.ready is low. The lockout and strike state is read
// and rewritten as an attempt moves from the input register to the result register.
// The secret is compared over all byte positions with no early exit.
`include "key_check_failure_throttle_unit_macros.svh"

module key_check_failure_throttle_unit import kcft_pkg::*; #(
	parameter int MAX_KEY_LEN = KEY_LEN_MAX
) (
	input logic clk,
	input logic arst_n,
	kcft_in_if.sink attempt,
	kcft_out_if.source result,
	kcft_cfg_if.sink cfg
);

	cfg_t cfg_r;

	// Input stage
	logic valid_s1;
	key_words_t try_words_s1;
	logic [5:0] try_len_s1;
	logic [TIME_W-1:0] now_s1;

	// Throttle state
	logic lock_active_q;
	logic [TIME_W-1:0] lock_end_q;
	logic [7:0] strike_count_q;
	logic [TIME_W-1:0] window_start_q;

	logic lock_active_d;
	logic [TIME_W-1:0] lock_end_d;
	logic [7:0] strike_count_d;
	logic [TIME_W-1:0] window_start_d;

	// Result register
	logic out_valid_q;
	verdict_t verdict_q;
	logic locked_out_q;
	logic [DUR_W-1:0] retry_q;

	verdict_t verdict_d;
	logic locked_out_d;
	logic [DUR_W-1:0] retry_d;

	logic accept_in;
	logic advance;
	logic key_match;
	logic [TIME_W-1:0] lock_diff;
	logic [TIME_W-1:0] remain;
	logic [TIME_W-1:0] win_elapsed;
	logic lock_pending;
	logic win_restart;
	logic [7:0] strike_next;
	logic hit_limit;

	kcft_cfg_regs u_cfg_regs (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg),
		.cfg_o (cfg_r)
	);

	kcft_key_cmp #(
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_key_cmp (
		.secret (cfg_r.secret),
		.secret_len (cfg_r.secret_len),
		.try_words (try_words_s1),
		.try_len (try_len_s1),
		.match (key_match)
	);

	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign attempt.ready = !valid_s1 || advance;
	assign accept_in = attempt.valid && attempt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			try_words_s1 <= {attempt.try_word3, attempt.try_word2,
				attempt.try_word1, attempt.try_word0};
			try_len_s1 <= attempt.try_len;
			now_s1 <= attempt.now_s;
		end
	end

	// A lock still holds while now has not reached its end on the wrapping clock.
	assign lock_diff = now_s1 - lock_end_q;
	assign lock_pending = lock_active_q && lock_diff[TIME_W-1];
	assign remain = lock_end_q - now_s1;

	assign win_elapsed = now_s1 - window_start_q;
	assign win_restart = (strike_count_q == 8'd0) ||
		(win_elapsed >= {1'b0, cfg_r.strike_window_s});
	assign strike_next = (win_restart ? 8'd0 : strike_count_q) + 8'd1;
	assign hit_limit = strike_next >= cfg_r.strike_limit;

	always_comb begin
		lock_active_d = lock_active_q;
		lock_end_d = lock_end_q;
		strike_count_d = strike_count_q;
		window_start_d = window_start_q;
		verdict_d = VERDICT_UNAUTH;
		locked_out_d = 1'b0;
		retry_d = '0;
		if (lock_pending) begin
			verdict_d = VERDICT_THROTTLED;
			locked_out_d = 1'b1;
			// A remaining time of exactly 2^31 saturates.
			retry_d = remain[TIME_W-1] ? RETRY_MAX : remain[DUR_W-1:0];
		end else begin
			lock_active_d = 1'b0;
			if (cfg_r.secret_len == 5'd0) begin
				verdict_d = VERDICT_UNAUTH;
			end else if (key_match) begin
				verdict_d = VERDICT_ALLOW;
				strike_count_d = 8'd0;
			end else begin
				verdict_d = VERDICT_UNAUTH;
				if (win_restart) begin
					window_start_d = now_s1;
				end
				if (hit_limit) begin
					lock_active_d = 1'b1;
					lock_end_d = now_s1 + {1'b0, cfg_r.lockout_s};
					strike_count_d = 8'd0;
					// A fresh lock ends lockout_s from now; a zero length is already over.
					locked_out_d = (cfg_r.lockout_s != '0);
					retry_d = cfg_r.lockout_s;
				end else begin
					strike_count_d = strike_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_active_q <= 1'b0;
			lock_end_q <= '0;
			strike_count_q <= '0;
			window_start_q <= '0;
		end else if (advance) begin
			lock_active_q <= lock_active_d;
			lock_end_q <= lock_end_d;
			strike_count_q <= strike_count_d;
			window_start_q <= window_start_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			verdict_q <= verdict_d;
			locked_out_q <= locked_out_d;
			retry_q <= retry_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.verdict = verdict_q;
	assign result.locked_out = locked_out_q;
	assign result.retry_after_s = retry_q;

	`KCFT_ASSERT_IMPL(a_throttled_locked, out_valid_q && verdict_q == VERDICT_THROTTLED, locked_out_q)
	`KCFT_ASSERT_IMPL(a_retry_iff_locked, out_valid_q, locked_out_q == (retry_q != '0))
	`KCFT_ASSERT_IMPL(a_allow_unlocked, out_valid_q && verdict_q == VERDICT_ALLOW, !locked_out_q)
	`KCFT_ASSERT_IMPL(a_lock_clears_strikes, lock_active_q, strike_count_q == 8'd0)
	`KCFT_ASSERT_NEXT(a_result_follows, advance, out_valid_q)

endmodule

// File: sv/kcft_cfg_regs.sv
// Configuration register file of the throttle unit.
module kcft_cfg_regs import kcft_pkg::*; (
	input logic clk,
	input logic arst_n,
	kcft_cfg_if.sink cfg,
	output cfg_t cfg_o
);

	cfg_t cfg_q;
	logic wr_en;

	assign cfg.ready = 1'b1;
	assign wr_en = cfg.valid && cfg.ready;
	assign cfg_o = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.secret <= '0;
			cfg_q.secret_len <= '0;
			cfg_q.strike_limit <= STRIKE_LIMIT_RST;
			cfg_q.strike_window_s <= STRIKE_WINDOW_RST;
			cfg_q.lockout_s <= LOCKOUT_RST;
		end else if (wr_en) begin
			case (cfg.idx)
				CFG_SECRET_WORD0: cfg_q.secret[0] <= cfg.data;
				CFG_SECRET_WORD1: cfg_q.secret[1] <= cfg.data;
				CFG_SECRET_WORD2: cfg_q.secret[2] <= cfg.data;
				CFG_SECRET_WORD3: cfg_q.secret[3] <= cfg.data;
				CFG_SECRET_LEN: cfg_q.secret_len <= cfg.data[4:0];
				CFG_STRIKE_LIMIT: cfg_q.strike_limit <= cfg.data[7:0];
				CFG_STRIKE_WINDOW: cfg_q.strike_window_s <= cfg.data[DUR_W-1:0];
				CFG_LOCKOUT: cfg_q.lockout_s <= cfg.data[DUR_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// File: sv/kcft_key_cmp.sv
// Constant-time comparison of a presented key with the configured secret.
module kcft_key_cmp import kcft_pkg::*; #(
	parameter int MAX_KEY_LEN = KEY_LEN_MAX
) (
	input key_words_t secret,
	input logic [4:0] secret_len,
	input key_words_t try_words,
	input logic [5:0] try_len,
	output logic match
);

	localparam logic [5:0] MAX_LEN = 6'(MAX_KEY_LEN);

	logic [31:0][7:0] sec_bytes;
	logic [31:0][7:0] try_bytes;
	logic [5:0] slen;
	logic [5:0] plen;
	logic [7:0] diff;
	logic [7:0] a_byte;
	logic [7:0] b_byte;

	// Word w, byte b sits at flat bit 64*w + 8*b, which is byte 8*w + b.
	assign sec_bytes = secret;
	assign try_bytes = try_words;

	assign slen = ({1'b0, secret_len} > MAX_LEN) ? MAX_LEN : {1'b0, secret_len};
	assign plen = (try_len > MAX_LEN) ? MAX_LEN + 6'd1 : try_len;

	// Every position up to the maximum length is folded in; there is no early exit.
	always_comb begin
		diff = {2'b00, slen ^ plen};
		a_byte = '0;
		b_byte = '0;
		for (int i = 0; i < 32; i++) begin
			if (i <= MAX_KEY_LEN) begin
				a_byte = (6'(i) < slen) ? sec_bytes[i] : 8'h00;
				b_byte = (6'(i) < plen) ? try_bytes[i] : 8'h00;
				diff = diff | (a_byte ^ b_byte);
			end
		end
	end

	assign match = (diff == 8'h00);

endmodule
